[hw/rtl/fnvtfc_pkg.sv]
// Shared types and constants for the FNV-1a 64-bit trailer frame checker.
package fnvtfc_pkg;

  localparam logic [63:0] FNV_OFFSET_BASIS = 64'hcbf29ce484222325;
  localparam logic [31:0] MAGIC_RESET      = 32'h4D455448;
  localparam logic [3:0]  MIN_BLOB_LEN     = 4'd12;
  localparam logic [3:0]  TRAILER_LEN      = 4'd8;
  localparam logic [3:0]  MAGIC_LEN        = 4'd4;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_SHORT = 2'd1,
    STATUS_HASH_BAD  = 2'd2,
    STATUS_MAGIC_BAD = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } byte_item_t;

  // Result handed from the checking core to the output register
  typedef struct packed {
    logic    vld;
    status_t status;
  } result_t;

endpackage

[hw/rtl/fnvtfc_ifs.sv]
// Valid/ready channel interfaces for byte items and status items.
interface fnvtfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface fnvtfc_status_if;
  logic       valid;
  logic       ready;
  logic [1:0] check_status;

  modport source (output valid, output check_status, input ready);
  modport sink   (input valid, input check_status, output ready);
endinterface

[hw/rtl/fnvtfc_in_reg.sv]
// Input register stage: captures one byte item and releases it to the core.
module fnvtfc_in_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  fnvtfc_pkg::byte_item_t in_item,
  input  logic                   out_free,
  output fnvtfc_pkg::byte_item_t item,
  output logic                   fire
);
  import fnvtfc_pkg::*;

  logic       vld_r;
  logic       vld_nxt;
  byte_item_t item_r;

  // Advance unless a last byte would land on an occupied output register
  assign fire     = vld_r && (!item_r.last_byte || out_free);
  assign in_ready = !vld_r || fire;
  assign item     = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (fire) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Hold payload until the next accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

[hw/rtl/fnvtfc_core.sv]
// Checking core: delay window, running FNV-1a hash, magic capture and status.
module fnvtfc_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [31:0]            cfg_wr_data,
  input  fnvtfc_pkg::byte_item_t item,
  input  logic                   fire,
  output fnvtfc_pkg::result_t    result
);
  import fnvtfc_pkg::*;

  logic [31:0] exp_magic_r;
  logic [63:0] hash_r;
  logic [63:0] hash_nxt;
  logic [63:0] hash_step;
  logic [7:0]  win_r [8];
  logic [31:0] magic_r;
  logic [31:0] magic_nxt;
  logic [31:0] magic_add;
  logic [3:0]  cnt_r;
  logic [3:0]  cnt_nxt;
  logic [3:0]  cnt_inc;
  logic [63:0] trailer;
  status_t     status;

  // Multiply by the FNV prime 2^40 + 0x1b3 as a sum of shifts
  function automatic logic [63:0] fnv_mul(input logic [63:0] h);
    fnv_mul = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  endfunction

  always_comb begin
    // Fold the byte leaving a full window into the hash
    if (cnt_r >= TRAILER_LEN) begin
      hash_step = fnv_mul(hash_r ^ {56'd0, win_r[0]});
    end else begin
      hash_step = hash_r;
    end

    // Trailer as the window reads after this byte shifts in
    trailer = {item.byte_value, win_r[7], win_r[6], win_r[5],
               win_r[4], win_r[3], win_r[2], win_r[1]};

    if (cnt_r < MAGIC_LEN) begin
      magic_add = {24'd0, item.byte_value} << {cnt_r[1:0], 3'b000};
    end else begin
      magic_add = 32'd0;
    end

    cnt_inc = (cnt_r >= MIN_BLOB_LEN) ? MIN_BLOB_LEN : cnt_r + 4'd1;

    // Checks in priority order
    if (cnt_inc < MIN_BLOB_LEN) begin
      status = STATUS_TOO_SHORT;
    end else if (trailer != hash_step) begin
      status = STATUS_HASH_BAD;
    end else if ((magic_r | magic_add) != exp_magic_r) begin
      status = STATUS_MAGIC_BAD;
    end else begin
      status = STATUS_OK;
    end

    hash_nxt  = hash_r;
    magic_nxt = magic_r;
    cnt_nxt   = cnt_r;
    if (fire) begin
      if (item.last_byte) begin
        hash_nxt  = FNV_OFFSET_BASIS;
        magic_nxt = 32'd0;
        cnt_nxt   = 4'd0;
      end else begin
        hash_nxt  = hash_step;
        magic_nxt = magic_r | magic_add;
        cnt_nxt   = cnt_inc;
      end
    end
  end

  assign result.vld    = fire && item.last_byte;
  assign result.status = status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_magic_r <= MAGIC_RESET;
      hash_r      <= FNV_OFFSET_BASIS;
      magic_r     <= 32'd0;
      cnt_r       <= 4'd0;
    end else begin
      if (cfg_wr_en) begin
        exp_magic_r <= cfg_wr_data;
      end
      hash_r  <= hash_nxt;
      magic_r <= magic_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Shift the delay window on every item
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < 7; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[7] <= item.byte_value;
    end
  end

endmodule

[hw/rtl/fnvtfc_out_reg.sv]
// Output register: holds one status item until the sink takes it.
module fnvtfc_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  fnvtfc_pkg::result_t result,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status
);
  import fnvtfc_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  status_t status_r;

  assign out_free   = !vld_r || out_ready;
  assign out_valid  = vld_r;
  assign out_status = status_r;

  always_comb begin
    vld_nxt = vld_r;
    if (result.vld) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Load a new status item
  always_ff @(posedge clk) begin
    if (result.vld) begin
      status_r <= result.status;
    end
  end

endmodule

[hw/rtl/fnvtfc_ifs_top_note.sv]
// Result channel driver: puts the output register onto the status channel.
module fnvtfc_status_drv (
  input  logic [1:0]              status,
  input  logic                    valid,
  fnvtfc_status_if.source         out_ch
);
  import fnvtfc_pkg::*;

  // Drive the result channel from the output register
  assign out_ch.valid        = valid;
  assign out_ch.check_status = status;

endmodule

[hw/rtl/fnvtfc1a64_top_placeholder.sv]
// Input channel adapter: packs the byte channel into one byte item.
module fnvtfc_byte_rcv (
  fnvtfc_byte_if.sink              in_ch,
  input  logic                     ready,
  output fnvtfc_pkg::byte_item_t   item
);
  import fnvtfc_pkg::*;

  // Pack payload and return ready
  assign item.byte_value = in_ch.byte_value;
  assign item.last_byte  = in_ch.last_byte;
  assign in_ch.ready     = ready;

endmodule

[hw/rtl/fnvtfc1a64_trailer_frame_checker_top.sv]
// Top level of the FNV-1a 64-bit trailer frame checker.
// Takes one byte item per clock cycle with no gaps of its own, but a last
// byte waits in the input register while out_free is low. The rate is set by
// the running-hash loop: the XOR and the shift-and-add multiply by the 64-bit
// FNV prime form one combinational path. The final eight bytes of a blob are
// its little-endian hash trailer, and the first four its little-endian magic
// word. Status codes: 0 ok, 1 too short (under 12 bytes), 2 hash mismatch, 3
// bad magic. Write expected_magic only while the block is idle; no clearing
// pass is needed after reset.
module fnv1a64_trailer_frame_checker_top (
  input  logic            clk,
  input  logic            rst_n,
  fnvtfc_byte_if.sink     in_ch,
  fnvtfc_status_if.source out_ch,
  input  logic            cfg_wr_en,
  input  logic [31:0]     cfg_wr_data
);
  import fnvtfc_pkg::*;

  byte_item_t in_item;
  byte_item_t item;
  logic       in_ready;
  logic       fire;
  logic       out_free;
  logic       out_valid;
  logic [1:0] out_status;
  result_t    result;

  fnvtfc_byte_rcv u_byte_rcv (
    .in_ch (in_ch),
    .ready (in_ready),
    .item  (in_item)
  );

  fnvtfc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_free (out_free),
    .item     (item),
    .fire     (fire)
  );

  fnvtfc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .fire        (fire),
    .result      (result)
  );

  fnvtfc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .result     (result),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .out_status (out_status)
  );

  fnvtfc_status_drv u_status_drv (
    .status (out_status),
    .valid  (out_valid),
    .out_ch (out_ch)
  );

endmodule
